@@ rtl/bffa_pkg.sv @@
// Shared types, widths and constants for the bitmap first-fit allocator.
`default_nettype none

package bffa_pkg;

    // Default geometry of the allocation map.
    localparam int MAP_UNITS_DEF = 65536;
    localparam int WORD_BITS_DEF = 32;

    // Widths of the transfer payload fields.
    localparam int ACT_W   = 1;
    localparam int OFS_W   = 16;
    localparam int LEN_W   = 17;
    localparam int START_W = 16;

    // Configuration register.
    localparam int               POOL_W     = 17;
    localparam logic [POOL_W-1:0] POOL_RESET = 17'd65536;
    localparam int               APB_DATA_W = 32;
    localparam int               APB_ADDR_W = 3;
    localparam logic             REG_POOL_SIZE = 1'b0;

    // Request actions.
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_RANGE   = 2'd2
    } status_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_SETUP,
        S_MODIFY,
        S_RESP
    } state_t;

    // Decisions of one scan step.
    typedef struct packed {
        logic found;
        logic fail;
        logic advance;
    } scan_flags_t;

endpackage

`default_nettype wire

@@ rtl/bffa_req_if.sv @@
// Request channel: action, offset and length with a valid/ready handshake.
`default_nettype none

interface bffa_req_if;
    logic                        valid;
    logic                        ready;
    logic                        action;
    logic [bffa_pkg::OFS_W-1:0]  offset;
    logic [bffa_pkg::LEN_W-1:0]  length;

    modport source (output valid, output action, output offset, output length, input ready);
    modport sink (input valid, input action, input offset, input length, output ready);
endinterface

`default_nettype wire

@@ rtl/bffa_rsp_if.sv @@
// Response channel: status and start unit with a valid/ready handshake.
`default_nettype none

interface bffa_rsp_if;
    logic                         valid;
    logic                         ready;
    bffa_pkg::status_t            status;
    logic [bffa_pkg::START_W-1:0] start_unit;

    modport source (output valid, output status, output start_unit, input ready);
    modport sink (input valid, input status, input start_unit, output ready);
endinterface

`default_nettype wire

@@ rtl/bffa_mem.sv @@
// Bitmap word store with one write port and one registered read port.
`default_nettype none

module bffa_mem #(
    parameter int DEPTH = 2048,
    parameter int WIDTH = 32,
    parameter int AW    = 11
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/bffa_scan.sv @@
// One scan step over a bitmap word: finds the next blocking bit and updates the free run.
`default_nettype none

module bffa_scan #(
    parameter int WORD_BITS = 32,
    parameter int SPAN_W    = 17,
    parameter int CNT_W     = 17
) (
    input  wire logic [WORD_BITS-1:0]          word,
    input  wire logic [SPAN_W-1:0]             base,
    input  wire logic [$clog2(WORD_BITS)-1:0]  pos,
    input  wire logic [CNT_W-1:0]              run,
    input  wire logic [CNT_W-1:0]              length,
    input  wire logic [CNT_W-1:0]              limit,
    output bffa_pkg::scan_flags_t              flags,
    output logic      [$clog2(WORD_BITS)-1:0]  pos_next,
    output logic      [CNT_W-1:0]              run_next,
    output logic      [CNT_W-1:0]              start
);
    import bffa_pkg::*;

    localparam int BIT_W = $clog2(WORD_BITS);
    localparam int PW    = BIT_W + 1;
    localparam logic [WORD_BITS-1:0] ONES = '1;

    logic [CNT_W-1:0]     base_ext;
    logic [CNT_W-1:0]     rem;
    logic [WORD_BITS-1:0] avail;
    logic [WORD_BITS-1:0] cand;
    logic [PW-1:0]        lo;
    logic                 has;
    logic [PW-1:0]        seg;
    logic [CNT_W-1:0]     total;
    logic [CNT_W-1:0]     hp;

    // Units at or above the limit count as blocked.
    always_comb
    begin
        base_ext = CNT_W'(base);
        rem      = limit - base_ext;
        if (base_ext >= limit)
        begin
            avail = '0;
        end
        else if (rem >= CNT_W'(WORD_BITS))
        begin
            avail = ONES;
        end
        else
        begin
            avail = ONES >> (PW'(WORD_BITS) - PW'(rem[BIT_W-1:0]));
        end
        cand = (word | ~avail) & (ONES << pos);
    end

    // Lowest blocking bit at or above the current position.
    always_comb
    begin
        lo = PW'(WORD_BITS);
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (cand[i])
            begin
                lo = PW'(i);
            end
        end
        has = |cand;
    end

    // Run arithmetic and decisions.
    always_comb
    begin
        seg            = lo - {1'b0, pos};
        total          = run + CNT_W'(seg);
        hp             = base_ext + CNT_W'(lo);
        start          = base_ext + CNT_W'(pos) - run;
        flags.found    = (total >= length);
        flags.fail     = !flags.found && (hp >= limit);
        flags.advance  = !has || (lo == PW'(WORD_BITS - 1));
        pos_next       = has ? (lo[BIT_W-1:0] + BIT_W'(1)) : '0;
        run_next       = has ? '0 : total;
    end

endmodule

`default_nettype wire

@@ rtl/bffa_cfg.sv @@
// APB register block holding the pool size.
`default_nettype none

module bffa_cfg (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [bffa_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [bffa_pkg::APB_DATA_W-1:0]     pwdata,
    output logic      [bffa_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                     pready,
    output logic      [bffa_pkg::POOL_W-1:0]         pool_size
);
    import bffa_pkg::*;

    logic                pool_size_sel;
    logic [POOL_W-1:0]   pool_size_reg;
    logic [POOL_W-1:0]   pool_size_next;

    assign pool_size_sel = (paddr[APB_ADDR_W-1:2] == REG_POOL_SIZE);
    assign pready        = 1'b1;
    assign pool_size     = pool_size_reg;

    // Register update on a completed write transfer.
    always_comb
    begin
        pool_size_next = pool_size_reg;
        if (psel && penable && pwrite && pready && pool_size_sel)
        begin
            pool_size_next = pwdata[POOL_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_size_reg <= POOL_RESET;
        end
        else
        begin
            pool_size_reg <= pool_size_next;
        end
    end

    // Read back.
    always_comb
    begin
        prdata = '0;
        if (pool_size_sel)
        begin
            prdata = APB_DATA_W'(pool_size_reg);
        end
    end

endmodule

`default_nettype wire

@@ rtl/bitmap_first_fit_allocator.sv @@
// Top level of the bitmap first-fit allocator: sequencer, bitmap store and output register.
`default_nettype none

// The block keeps one used bit per allocation unit in a word-wide memory of
// MAP_UNITS/WORD_BITS words, rounded up (WORD_BITS a power of two). After reset
// it runs a clearing pass that writes zero to every word, and it takes no request
// until that ends; pool_size writes are taken at any time. One request is worked
// at a time. An allocation reads the map from word 0 and one scan unit steps
// through it word by word, with one more step for each used unit it meets below
// the top bit of a word; the claim then reads and rewrites each word the run
// touches. A free reads and rewrites each word it touches. A zero-length request,
// a free past the map and an allocation longer than the pool go straight to the
// response. The memory port reads one word and writes one word per cycle. A new
// request is taken while the previous result still waits in the output register.
module bitmap_first_fit_allocator #(
    parameter int MAP_UNITS = bffa_pkg::MAP_UNITS_DEF,
    parameter int WORD_BITS = bffa_pkg::WORD_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    bffa_req_if.sink                                 req,
    bffa_rsp_if.source                               rsp,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [bffa_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [bffa_pkg::APB_DATA_W-1:0]     pwdata,
    output logic      [bffa_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                     pready
);
    import bffa_pkg::*;

    localparam int MAP_WORDS = (MAP_UNITS + WORD_BITS - 1) / WORD_BITS;
    localparam int WADDR_W   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int PW        = BIT_W + 1;
    localparam int SPAN_W    = $clog2(MAP_WORDS * WORD_BITS + 1);
    localparam int CNT_W     = (SPAN_W > LEN_W) ? SPAN_W : LEN_W;
    localparam logic [WORD_BITS-1:0] ONES = '1;

    // Control registers.
    state_t               state_reg, state_next;
    logic [WADDR_W-1:0]   clr_idx_reg, clr_idx_next;
    logic                 out_valid_reg, out_valid_next;

    // Work and payload registers.
    logic [SPAN_W-1:0]    base_reg, base_next;
    logic [BIT_W-1:0]     pos_reg, pos_next;
    logic [CNT_W-1:0]     run_reg, run_next;
    logic [CNT_W-1:0]     len_reg, len_next;
    logic [CNT_W-1:0]     cur_reg, cur_next;
    logic [CNT_W-1:0]     rem_reg, rem_next;
    logic                 op_set_reg, op_set_next;
    status_t              res_status_reg, res_status_next;
    logic [START_W-1:0]   res_start_reg, res_start_next;
    status_t              out_status_reg, out_status_next;
    logic [START_W-1:0]   out_start_reg, out_start_next;

    // Memory port.
    logic                 mem_wr_en;
    logic [WADDR_W-1:0]   mem_wr_addr;
    logic [WORD_BITS-1:0] mem_wr_data;
    logic                 mem_rd_en;
    logic [WADDR_W-1:0]   mem_rd_addr;
    logic [WORD_BITS-1:0] mem_rd_data;

    // Scan unit outputs.
    scan_flags_t          scan_flags;
    logic [BIT_W-1:0]     scan_pos_next;
    logic [CNT_W-1:0]     scan_run_next;
    logic [CNT_W-1:0]     scan_start;

    // Configuration and derived limit.
    logic [POOL_W-1:0]    pool_size;
    logic [CNT_W-1:0]     limit;
    logic [CNT_W-1:0]     req_len;
    logic [CNT_W:0]       free_end;
    logic [SPAN_W-1:0]    base_step;

    // Claim or release mask for the current word.
    logic [BIT_W-1:0]     cur_bit;
    logic [PW-1:0]        room;
    logic [PW-1:0]        take;
    logic [WORD_BITS-1:0] word_mask;
    logic [CNT_W-1:0]     cur_step;

    bffa_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .pool_size (pool_size)
    );

    bffa_mem #(
        .DEPTH (MAP_WORDS),
        .WIDTH (WORD_BITS),
        .AW    (WADDR_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    bffa_scan #(
        .WORD_BITS (WORD_BITS),
        .SPAN_W    (SPAN_W),
        .CNT_W     (CNT_W)
    ) u_scan (
        .word     (mem_rd_data),
        .base     (base_reg),
        .pos      (pos_reg),
        .run      (run_reg),
        .length   (len_reg),
        .limit    (limit),
        .flags    (scan_flags),
        .pos_next (scan_pos_next),
        .run_next (scan_run_next),
        .start    (scan_start)
    );

    // Pool size saturates at the map size.
    always_comb
    begin
        if (CNT_W'(pool_size) > CNT_W'(MAP_UNITS))
        begin
            limit = CNT_W'(MAP_UNITS);
        end
        else
        begin
            limit = CNT_W'(pool_size);
        end
        req_len   = CNT_W'(req.length);
        free_end  = (CNT_W + 1)'(req.offset) + (CNT_W + 1)'(req.length);
        base_step = base_reg + SPAN_W'(WORD_BITS);
    end

    // Mask of the units handled in the current word.
    always_comb
    begin
        cur_bit = cur_reg[BIT_W-1:0];
        room    = PW'(WORD_BITS) - PW'(cur_bit);
        if (rem_reg < CNT_W'(room))
        begin
            take = rem_reg[PW-1:0];
        end
        else
        begin
            take = room;
        end
        word_mask = (ONES << cur_bit) & (ONES >> (room - take));
        cur_step  = cur_reg + CNT_W'(take);
    end

    assign req.ready      = (state_reg == S_IDLE);
    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.start_unit = out_start_reg;

    // Sequencer: next state, memory control and work registers.
    always_comb
    begin
        state_next      = state_reg;
        clr_idx_next    = clr_idx_reg;
        out_valid_next  = out_valid_reg;
        base_next       = base_reg;
        pos_next        = pos_reg;
        run_next        = run_reg;
        len_next        = len_reg;
        cur_next        = cur_reg;
        rem_next        = rem_reg;
        op_set_next     = op_set_reg;
        res_status_next = res_status_reg;
        res_start_next  = res_start_reg;
        out_status_next = out_status_reg;
        out_start_next  = out_start_reg;
        mem_wr_en       = 1'b0;
        mem_wr_addr     = cur_reg[BIT_W+WADDR_W-1:BIT_W];
        mem_wr_data     = '0;
        mem_rd_en       = 1'b0;
        mem_rd_addr     = cur_reg[BIT_W+WADDR_W-1:BIT_W];

        // A taken response frees the output register.
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_wr_en    = 1'b1;
                mem_wr_addr  = clr_idx_reg;
                mem_wr_data  = '0;
                clr_idx_next = clr_idx_reg + WADDR_W'(1);
                if (clr_idx_reg == WADDR_W'(MAP_WORDS - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (req.valid)
                begin
                    len_next       = req_len;
                    res_start_next = '0;
                    if (req.action == ACT_ALLOC)
                    begin
                        if (req_len == '0)
                        begin
                            res_status_next = ST_OK;
                            state_next      = S_RESP;
                        end
                        else if (req_len > limit)
                        begin
                            res_status_next = ST_NOSPACE;
                            state_next      = S_RESP;
                        end
                        else
                        begin
                            base_next   = '0;
                            pos_next    = '0;
                            run_next    = '0;
                            mem_rd_en   = 1'b1;
                            mem_rd_addr = '0;
                            state_next  = S_SCAN;
                        end
                    end
                    else
                    begin
                        if (free_end > (CNT_W + 1)'(MAP_UNITS))
                        begin
                            res_status_next = ST_RANGE;
                            state_next      = S_RESP;
                        end
                        else if (req_len == '0)
                        begin
                            res_status_next = ST_OK;
                            state_next      = S_RESP;
                        end
                        else
                        begin
                            cur_next    = CNT_W'(req.offset);
                            rem_next    = req_len;
                            op_set_next = 1'b0;
                            state_next  = S_SETUP;
                        end
                    end
                end
            end

            S_SCAN:
            begin
                if (scan_flags.found)
                begin
                    cur_next       = scan_start;
                    rem_next       = len_reg;
                    op_set_next    = 1'b1;
                    res_start_next = scan_start[START_W-1:0];
                    state_next     = S_SETUP;
                end
                else if (scan_flags.fail)
                begin
                    res_status_next = ST_NOSPACE;
                    res_start_next  = '0;
                    state_next      = S_RESP;
                end
                else
                begin
                    pos_next = scan_pos_next;
                    run_next = scan_run_next;
                    if (scan_flags.advance)
                    begin
                        base_next   = base_step;
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = base_step[BIT_W+WADDR_W-1:BIT_W];
                    end
                end
            end

            S_SETUP:
            begin
                mem_rd_en  = 1'b1;
                state_next = S_MODIFY;
            end

            S_MODIFY:
            begin
                mem_wr_en = 1'b1;
                if (op_set_reg)
                begin
                    mem_wr_data = mem_rd_data | word_mask;
                end
                else
                begin
                    mem_wr_data = mem_rd_data & ~word_mask;
                end
                if (rem_reg == CNT_W'(take))
                begin
                    res_status_next = ST_OK;
                    state_next      = S_RESP;
                end
                else
                begin
                    cur_next    = cur_step;
                    rem_next    = rem_reg - CNT_W'(take);
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = cur_step[BIT_W+WADDR_W-1:BIT_W];
                end
            end

            S_RESP:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_start_next  = res_start_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Work and payload registers.
    always_ff @(posedge clk)
    begin
        base_reg       <= base_next;
        pos_reg        <= pos_next;
        run_reg        <= run_next;
        len_reg        <= len_next;
        cur_reg        <= cur_next;
        rem_reg        <= rem_next;
        op_set_reg     <= op_set_next;
        res_status_reg <= res_status_next;
        res_start_reg  <= res_start_next;
        out_status_reg <= out_status_next;
        out_start_reg  <= out_start_next;
    end

endmodule

`default_nettype wire
